### rtl/afps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afps_pkg
// Shared types and constants of the autofocus peak search unit: register
// indexes, reset values, configuration, request and result bundles.
// ----------------------------------------------------------------------------
package afps_pkg;

    localparam int POS_W      = 32;
    localparam int SCORE_W    = 32;
    localparam int SPAN_W     = 20;
    localparam int STEP_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int FRAME_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SPAN_W-1:0]  COARSE_SPAN_RST   = SPAN_W'(30000);
    localparam logic [STEP_W-1:0]  COARSE_STEP_RST   = STEP_W'(1000);
    localparam logic [SPAN_W-1:0]  FINE_SPAN_RST     = SPAN_W'(10000);
    localparam logic [STEP_W-1:0]  FINE_STEP_RST     = STEP_W'(300);
    localparam logic [FRAC_W-1:0]  DROP_FRACTION_RST = FRAC_W'(3277);
    localparam logic [POS_W-1:0]   ABORT_LIMIT_RST   = POS_W'(500000);
    localparam logic [FRAME_W-1:0] FRAME_MAX         = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COARSE_SPAN   = 3'd0,
        REG_COARSE_STEP   = 3'd1,
        REG_FINE_SPAN     = 3'd2,
        REG_FINE_STEP     = 3'd3,
        REG_DROP_FRACTION = 3'd4,
        REG_ABORT_LIMIT   = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_SCORE = 1'b1
    } action_t;

    typedef struct packed {
        logic [SPAN_W-1:0]       coarse_span;
        logic [STEP_W-1:0]       coarse_step;
        logic [SPAN_W-1:0]       fine_span;
        logic [STEP_W-1:0]       fine_step;
        logic [FRAC_W-1:0]       drop_fraction;
        logic signed [POS_W-1:0] abort_position_limit;
    } cfg_t;

    typedef struct packed {
        logic                    action;
        logic                    fine_mode;
        logic signed [POS_W-1:0] home_position;
        logic [SCORE_W-1:0]      sharpness;
    } req_t;

    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] target_position;
        logic                    search_done;
        logic                    early_stop;
        logic [SCORE_W-1:0]      best_sharpness;
        logic [FRAME_W-1:0]      frames_taken;
    } res_t;

endpackage

### rtl/autofocus_peak_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autofocus_peak_search_unit
// Focus sweep controller: start and score requests in, stage move commands
// out, with best score, early stop and end of sweep detection.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while the input does not stall. A
// request is captured in an input register, decided by the search logic (a
// 16 x 32 multiply for the drop test and a few 33 bit adds and compares) and
// the move command lands in the result register when the request is fired
// into the search logic. A score request while no search runs gives no
// command.
// The input side keeps taking requests while a command waits under stall,
// until both registers are full. Configuration writes take effect at once
// and are meant for idle periods.
module autofocus_peak_search_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [afps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [afps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic                               fine_mode,
    input  logic signed [afps_pkg::POS_W-1:0]  home_position,
    input  logic [afps_pkg::SCORE_W-1:0]       sharpness,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [afps_pkg::POS_W-1:0]  target_position,
    output logic                               search_done,
    output logic                               early_stop,
    output logic [afps_pkg::SCORE_W-1:0]       best_sharpness,
    output logic [afps_pkg::FRAME_W-1:0]       frames_taken
);
    import afps_pkg::*;

    cfg_t cfg;
    req_t req_reg;
    logic in_valid_reg;
    res_t core_res;
    res_t out_reg;
    logic fire;
    logic in_take;

    afps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afps_search_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req_reg),
        .fire  (fire),
        .res   (core_res)
    );

    assign fire     = in_valid_reg && (!out_reg.valid || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg.action        <= action;
            req_reg.fine_mode     <= fine_mode;
            req_reg.home_position <= home_position;
            req_reg.sharpness     <= sharpness;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (fire)
            out_reg <= core_res;
        else if (!out_stall)
            out_reg.valid <= 1'b0;
    end

    assign out_valid       = out_reg.valid;
    assign target_position = out_reg.target_position;
    assign search_done     = out_reg.search_done;
    assign early_stop      = out_reg.early_stop;
    assign best_sharpness  = out_reg.best_sharpness;
    assign frames_taken    = out_reg.frames_taken;

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_reg.valid && out_stall)
        else $error("input stalled while result register free");

    a_request_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !in_take |=> !in_valid_reg)
        else $error("request kept after being processed");

    a_start_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req_reg.action == ACT_START |=> out_reg.valid && !out_reg.search_done)
        else $error("start request gave no move command");

endmodule

### rtl/afps_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afps_cfg_regs
// Configuration register file: write-only, indexed, reset to defaults.
// ----------------------------------------------------------------------------
module afps_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [afps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output afps_pkg::cfg_t                   cfg
);
    import afps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COARSE_SPAN:   cfg_next.coarse_span   = cfg_data[SPAN_W-1:0];
                REG_COARSE_STEP:   cfg_next.coarse_step   = cfg_data[STEP_W-1:0];
                REG_FINE_SPAN:     cfg_next.fine_span     = cfg_data[SPAN_W-1:0];
                REG_FINE_STEP:     cfg_next.fine_step     = cfg_data[STEP_W-1:0];
                REG_DROP_FRACTION: cfg_next.drop_fraction = cfg_data[FRAC_W-1:0];
                REG_ABORT_LIMIT:   cfg_next.abort_position_limit = $signed(cfg_data[POS_W-1:0]);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coarse_span          <= COARSE_SPAN_RST;
            cfg_reg.coarse_step          <= COARSE_STEP_RST;
            cfg_reg.fine_span            <= FINE_SPAN_RST;
            cfg_reg.fine_step            <= FINE_STEP_RST;
            cfg_reg.drop_fraction        <= DROP_FRACTION_RST;
            cfg_reg.abort_position_limit <= $signed(ABORT_LIMIT_RST);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/afps_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afps_search_core
// Search state and combinational decision logic: start setup, best tracking,
// drop test, step advance and end of sweep.
// ----------------------------------------------------------------------------
module afps_search_core (
    input  logic           clk,
    input  logic           rst_n,
    input  afps_pkg::cfg_t cfg,
    input  afps_pkg::req_t req,
    input  logic           fire,
    output afps_pkg::res_t res
);
    import afps_pkg::*;

    logic                    searching_reg, searching_next;
    logic                    best_valid_reg, best_valid_next;
    logic signed [POS_W-1:0] current_reg, current_next;
    logic signed [POS_W-1:0] top_reg, top_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic signed [POS_W-1:0] best_pos_reg, best_pos_next;
    logic [SCORE_W-1:0]      best_score_reg, best_score_next;
    logic [FRAME_W-1:0]      frame_count_reg, frame_count_next;

    logic [SPAN_W-1:0]            span;
    logic signed [POS_W:0]        half_ext;
    logic signed [POS_W:0]        home_ext;
    logic signed [POS_W:0]        low_sum;
    logic signed [POS_W:0]        high_sum;
    logic signed [POS_W-1:0]      low_sat;
    logic signed [POS_W-1:0]      high_sat;
    logic                         take_best;
    logic [SCORE_W-1:0]           diff;
    logic [SCORE_W+FRAC_W-1:0]    drop_lhs;
    logic [SCORE_W+FRAC_W-1:0]    drop_rhs;
    logic                         early;
    logic [STEP_W-1:0]            step_eff;
    logic signed [POS_W:0]        next_pos;
    logic                         done;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W] && !v[POS_W-1])
            r = {1'b1, {(POS_W-1){1'b0}}};
        else if (!v[POS_W] && v[POS_W-1])
            r = {1'b0, {(POS_W-1){1'b1}}};
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    // start setup
    always_comb
    begin
        span     = req.fine_mode ? cfg.fine_span : cfg.coarse_span;
        half_ext = $signed({{(POS_W+1-SPAN_W+1){1'b0}}, span[SPAN_W-1:1]});
        home_ext = {req.home_position[POS_W-1], req.home_position};
        low_sum  = home_ext - half_ext;
        high_sum = home_ext + half_ext;
        low_sat  = sat_pos(low_sum);
        high_sat = sat_pos(high_sum);
    end

    // score evaluation
    always_comb
    begin
        take_best = !best_valid_reg || (req.sharpness >= best_score_reg);
        diff      = best_score_reg - req.sharpness;
        drop_lhs  = {diff, {FRAC_W{1'b0}}};
        drop_rhs  = (SCORE_W+FRAC_W)'(cfg.drop_fraction) * (SCORE_W+FRAC_W)'(best_score_reg);
        early     = !take_best && (drop_lhs > drop_rhs)
                    && (best_pos_reg < cfg.abort_position_limit);
        step_eff  = (step_reg == '0) ? STEP_W'(1) : step_reg;
        next_pos  = {current_reg[POS_W-1], current_reg}
                    + $signed({{(POS_W+1-STEP_W){1'b0}}, step_eff});
        done      = early || !(next_pos < $signed({top_reg[POS_W-1], top_reg}));
    end

    always_comb
    begin
        searching_next   = searching_reg;
        best_valid_next  = best_valid_reg;
        current_next     = current_reg;
        top_next         = top_reg;
        step_next        = step_reg;
        best_pos_next    = best_pos_reg;
        best_score_next  = best_score_reg;
        frame_count_next = frame_count_reg;
        res              = '0;

        if (req.action == ACT_START)
        begin
            step_next           = req.fine_mode ? cfg.fine_step : cfg.coarse_step;
            current_next        = low_sat;
            top_next            = high_sat;
            best_pos_next       = req.home_position;
            best_score_next     = '0;
            best_valid_next     = 1'b0;
            frame_count_next    = '0;
            searching_next      = 1'b1;
            res.valid           = 1'b1;
            res.target_position = low_sat;
        end
        else if (searching_reg)
        begin
            if (frame_count_reg != FRAME_MAX)
                frame_count_next = frame_count_reg + FRAME_W'(1);
            if (take_best)
            begin
                best_score_next = req.sharpness;
                best_pos_next   = current_reg;
                best_valid_next = 1'b1;
            end
            res.valid          = 1'b1;
            res.best_sharpness = best_score_next;
            res.frames_taken   = frame_count_next;
            if (done)
            begin
                searching_next      = 1'b0;
                res.target_position = best_pos_next;
                res.search_done     = 1'b1;
                res.early_stop      = early;
            end
            else
            begin
                current_next        = next_pos[POS_W-1:0];
                res.target_position = next_pos[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            searching_reg   <= 1'b0;
            best_valid_reg  <= 1'b0;
            current_reg     <= '0;
            top_reg         <= '0;
            step_reg        <= '0;
            best_pos_reg    <= '0;
            best_score_reg  <= '0;
            frame_count_reg <= '0;
        end
        else if (fire)
        begin
            searching_reg   <= searching_next;
            best_valid_reg  <= best_valid_next;
            current_reg     <= current_next;
            top_reg         <= top_next;
            step_reg        <= step_next;
            best_pos_reg    <= best_pos_next;
            best_score_reg  <= best_score_next;
            frame_count_reg <= frame_count_next;
        end
    end

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.search_done |=> !searching_reg)
        else $error("search still running after final result");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.action == ACT_START |=> searching_reg && !best_valid_reg
            && frame_count_reg == '0)
        else $error("start did not set up a fresh search");

    a_early_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.early_stop |-> res.search_done && !take_best)
        else $error("early stop without end of search");

    a_idle_score_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !searching_reg && req.action == ACT_SCORE |-> !res.valid)
        else $error("score while idle produced a result");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the autofocus peak search unit. A directed plan
// covers reset state, saturated sweep bounds, zero span and step, equal scores
// and the exact drop boundary. Random hill-shaped focus sweeps follow under
// changing register setups. Every move command is checked against a local
// search model or the plan's expected move, with random gaps on both channels
// and long output hold-offs.
module testbench;
    import afps_pkg::*;

    localparam int SETTLE_CYCLES  = 4;
    localparam int SINK_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 220;
    localparam int MAX_PRINTS     = 40;

    typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

    typedef enum {
        SETUP_MODERATE,
        SETUP_TOP,
        SETUP_BOTTOM,
        SETUP_TINY
    } setup_t;

    typedef struct {
        row_kind_t   kind;
        req_t        rq;
        cfg_reg_t    idx;
        logic [31:0] data;
        bit          typed;
        bit          has_move;
        res_t        move;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      action;
    logic                      fine_mode;
    logic signed [POS_W-1:0]   home_position;
    logic [SCORE_W-1:0]        sharpness;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [POS_W-1:0]   target_position;
    logic                      search_done;
    logic                      early_stop;
    logic [SCORE_W-1:0]        best_sharpness;
    logic [FRAME_W-1:0]        frames_taken;

    // search model state
    cfg_t                      focus_cfg;
    bit                        hunting;
    bit                        have_best;
    logic signed [POS_W-1:0]   pos_now;
    logic signed [POS_W-1:0]   pos_top;
    logic signed [POS_W-1:0]   pos_best;
    logic [STEP_W-1:0]         step_now;
    logic [SCORE_W-1:0]        score_best;
    logic [FRAME_W-1:0]        frame_cnt;

    res_t      pending_moves[$];
    plan_row_t plan[$];

    int hold_requests;
    int n_items;
    int n_searches;
    int n_early;
    int n_top;
    int n_ignored;
    int n_checked;
    int n_errors;
    int quiet_cycles;

    autofocus_peak_search_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .fine_mode       (fine_mode),
        .home_position   (home_position),
        .sharpness       (sharpness),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .target_position (target_position),
        .search_done     (search_done),
        .early_stop      (early_stop),
        .best_sharpness  (best_sharpness),
        .frames_taken    (frames_taken)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < -longint'(64'h8000_0000))
            return 32'sh8000_0000;
        return v[POS_W-1:0];
    endfunction

    function automatic bit predict_move(input req_t rq, output res_t mv);
        logic [SPAN_W-1:0]  span;
        logic [STEP_W-1:0]  st;
        logic [SCORE_W-1:0] shortfall;
        longint             half;
        longint             nxt;
        longint             lhs;
        longint             rhs;
        bit                 dropped;
        bit                 ends;
        mv = '0;
        mv.valid = 1'b1;
        if (rq.action == ACT_START)
        begin
            span      = rq.fine_mode ? focus_cfg.fine_span : focus_cfg.coarse_span;
            half      = longint'(span >> 1);
            step_now  = rq.fine_mode ? focus_cfg.fine_step : focus_cfg.coarse_step;
            pos_now   = clamp_pos(longint'($signed(rq.home_position)) - half);
            pos_top   = clamp_pos(longint'($signed(rq.home_position)) + half);
            pos_best  = rq.home_position;
            score_best = '0;
            have_best = 1'b0;
            frame_cnt = '0;
            hunting   = 1'b1;
            mv.target_position = pos_now;
            return 1'b1;
        end
        if (!hunting)
            return 1'b0;
        if (frame_cnt != FRAME_MAX)
            frame_cnt++;
        dropped = 1'b0;
        if (!have_best || rq.sharpness >= score_best)
        begin
            score_best = rq.sharpness;
            pos_best   = pos_now;
            have_best  = 1'b1;
        end
        else
        begin
            shortfall = score_best - rq.sharpness;
            lhs = longint'(shortfall) << 16;
            rhs = longint'(focus_cfg.drop_fraction) * longint'(score_best);
            if (lhs > rhs && $signed(pos_best) < $signed(focus_cfg.abort_position_limit))
                dropped = 1'b1;
        end
        ends = dropped;
        if (!ends)
        begin
            st  = (step_now != '0) ? step_now : STEP_W'(1);
            nxt = longint'(pos_now) + longint'(st);
            if (nxt < longint'(pos_top))
                pos_now = nxt[POS_W-1:0];
            else
                ends = 1'b1;
        end
        if (ends)
            hunting = 1'b0;
        mv.target_position = ends ? pos_best : pos_now;
        mv.search_done     = ends;
        mv.early_stop      = dropped;
        mv.best_sharpness  = score_best;
        mv.frames_taken    = frame_cnt;
        return 1'b1;
    endfunction

    function automatic plan_row_t blank_row();
        plan_row_t row;
        row.kind     = ROW_REQ;
        row.rq       = '0;
        row.idx      = REG_COARSE_SPAN;
        row.data     = '0;
        row.typed    = 1'b0;
        row.has_move = 1'b0;
        row.move     = '0;
        return row;
    endfunction

    function automatic plan_row_t req_row(input action_t act, input bit fm,
                                          input logic [31:0] home,
                                          input logic [31:0] score);
        plan_row_t row;
        row = blank_row();
        row.kind             = ROW_REQ;
        row.rq.action        = act;
        row.rq.fine_mode     = fm;
        row.rq.home_position = home;
        row.rq.sharpness     = score;
        return row;
    endfunction

    function automatic plan_row_t move_row(input action_t act, input bit fm,
                                           input logic [31:0] home,
                                           input logic [31:0] score, input bit has,
                                           input logic [31:0] target, input bit done,
                                           input bit early, input logic [31:0] best,
                                           input logic [15:0] frames);
        plan_row_t row;
        row = req_row(act, fm, home, score);
        row.typed                    = 1'b1;
        row.has_move                 = has;
        row.move.valid               = 1'b1;
        row.move.target_position     = target;
        row.move.search_done         = done;
        row.move.early_stop          = early;
        row.move.best_sharpness      = best;
        row.move.frames_taken        = frames;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input cfg_reg_t idx, input logic [31:0] data);
        plan_row_t row;
        row = blank_row();
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic void add_row(input plan_row_t row);
        plan = {plan, row};
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        if (n_errors < MAX_PRINTS)
            $display("%0t mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        n_errors++;
    endtask

    task automatic wait_idle();
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        in_valid <= 1'b0;
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_COARSE_SPAN:   focus_cfg.coarse_span   = val[SPAN_W-1:0];
            REG_COARSE_STEP:   focus_cfg.coarse_step   = val[STEP_W-1:0];
            REG_FINE_SPAN:     focus_cfg.fine_span     = val[SPAN_W-1:0];
            REG_FINE_STEP:     focus_cfg.fine_step     = val[STEP_W-1:0];
            REG_DROP_FRACTION: focus_cfg.drop_fraction = val[FRAC_W-1:0];
            REG_ABORT_LIMIT:   focus_cfg.abort_position_limit = val;
            default:           ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_request(input req_t rq, input bit typed, input bit typed_has,
                                input res_t typed_move);
        int   gap;
        bit   has;
        res_t mv;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= rq.action;
        fine_mode     <= rq.fine_mode;
        home_position <= rq.home_position;
        sharpness     <= rq.sharpness;
        do
            @(posedge clk);
        while (in_stall);
        n_items++;
        has = predict_move(rq, mv);
        if (typed)
        begin
            has = typed_has;
            mv  = typed_move;
        end
        if (has)
            pending_moves = {pending_moves, mv};
        if (rq.action == ACT_START)
            n_searches++;
        else if (!has)
            n_ignored++;
        else if (mv.search_done && mv.early_stop)
            n_early++;
        else if (mv.search_done)
            n_top++;
    endtask

    task automatic apply_setup(input setup_t kind);
        logic [31:0] c_span;
        logic [31:0] c_step;
        logic [31:0] f_span;
        logic [31:0] f_step;
        logic [31:0] frac;
        logic [31:0] limit;
        c_span = $urandom_range(0, 40000);
        c_step = $urandom_range(1, 4000);
        f_span = $urandom_range(0, 8000);
        f_step = $urandom_range(1, 800);
        frac   = $urandom_range(0, 65535);
        case ($urandom_range(0, 3))
            0:       limit = $urandom;
            1:       limit = 32'h7FFF_FFFF;
            default: limit = int'($urandom_range(0, 200000)) - 100000;
        endcase
        case (kind)
            SETUP_TOP:
            begin
                c_span = 1000000;
                c_step = 100000;
                f_span = 32'hF_FFFF;
                f_step = 32'h1_FFFF;
                frac   = 32'hFFFF;
                limit  = 32'h7FFF_FFFF;
            end
            SETUP_BOTTOM:
            begin
                c_span = 0;
                c_step = 0;
                f_span = 1;
                f_step = 1;
                frac   = 0;
                limit  = 32'h8000_0000;
            end
            SETUP_TINY:
            begin
                c_span = $urandom_range(0, 60);
                c_step = $urandom_range(0, 3);
                f_span = $urandom_range(0, 20);
                f_step = $urandom_range(0, 1);
            end
            default: ;
        endcase
        write_reg(REG_COARSE_SPAN, c_span);
        write_reg(REG_COARSE_STEP, c_step);
        write_reg(REG_FINE_SPAN, f_span);
        write_reg(REG_FINE_STEP, f_step);
        write_reg(REG_DROP_FRACTION, frac);
        write_reg(REG_ABORT_LIMIT, limit);
    endtask

    // one sweep: start, then a noisy hill of scores until the search ends or is cut short
    task automatic run_search();
        req_t   rq;
        longint pk;
        longint slope;
        longint fall;
        longint sv;
        int     peak_at;
        int     offset;
        int     i;
        rq = '0;
        rq.action    = ACT_START;
        rq.fine_mode = 1'($urandom_range(0, 1));
        rq.sharpness = $urandom;
        case ($urandom_range(0, 9))
            0:       rq.home_position = $urandom;
            1:       rq.home_position = 32'h7FFF_FFFF - $urandom_range(0, 3000);
            2:       rq.home_position = 32'h8000_0000 + $urandom_range(0, 3000);
            default: rq.home_position = int'($urandom_range(0, 200000)) - 100000;
        endcase
        send_request(rq, 1'b0, 1'b0, '0);
        case ($urandom_range(0, 9))
            0:       pk = longint'(32'hFFFF_FFFF);
            1:       pk = $urandom_range(0, 50);
            default: pk = longint'($urandom);
        endcase
        slope   = pk >> $urandom_range(1, 8);
        peak_at = $urandom_range(0, 12);
        i = 0;
        while (hunting && i < 400 && $urandom_range(0, 99) >= 3)
        begin
            offset = (i > peak_at) ? i - peak_at : peak_at - i;
            fall   = longint'(offset) * slope;
            sv     = (fall >= pk) ? longint'(0) : pk - fall;
            sv     = sv ^ longint'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0)
                sv = longint'($urandom);
            rq.action        = ACT_SCORE;
            rq.fine_mode     = 1'($urandom_range(0, 1));
            rq.home_position = $urandom;
            rq.sharpness     = sv[SCORE_W-1:0];
            send_request(rq, 1'b0, 1'b0, '0);
            i++;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            rq.action    = ACT_SCORE;
            rq.sharpness = $urandom;
            send_request(rq, 1'b0, 1'b0, '0);
        end
    endtask

    // output side: random stalls, plus a long hold-off on request
    initial
    begin : sink
        int stall_left;
        int hold_left;
        int holds_served;
        out_stall    = 1'b0;
        stall_left   = 0;
        hold_left    = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                hold_left    = SINK_HOLD;
                holds_served = hold_requests;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = gap_len();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    always @(posedge clk)
    begin : check_moves
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_moves.size() == 0)
            begin
                report_mismatch("unrequested move", longint'(target_position), longint'(0));
            end
            else
            begin
                want = pending_moves.pop_front();
                n_checked++;
                if (target_position !== want.target_position)
                    report_mismatch("target_position", longint'(target_position),
                                    longint'($signed(want.target_position)));
                if (search_done !== want.search_done)
                    report_mismatch("search_done", longint'(search_done),
                                    longint'(want.search_done));
                if (early_stop !== want.early_stop)
                    report_mismatch("early_stop", longint'(early_stop),
                                    longint'(want.early_stop));
                if (best_sharpness !== want.best_sharpness)
                    report_mismatch("best_sharpness", longint'(best_sharpness),
                                    longint'(want.best_sharpness));
                if (frames_taken !== want.frames_taken)
                    report_mismatch("frames_taken", longint'(frames_taken),
                                    longint'(want.frames_taken));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request or move for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int phase_stop;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        action        = ACT_START;
        fine_mode     = 1'b0;
        home_position = '0;
        sharpness     = '0;
        hold_requests = 0;
        hunting       = 1'b0;
        have_best     = 1'b0;
        pos_now       = '0;
        pos_top       = '0;
        pos_best      = '0;
        step_now      = '0;
        score_best    = '0;
        frame_cnt     = '0;
        focus_cfg.coarse_span          = COARSE_SPAN_RST;
        focus_cfg.coarse_step          = COARSE_STEP_RST;
        focus_cfg.fine_span            = FINE_SPAN_RST;
        focus_cfg.fine_step            = FINE_STEP_RST;
        focus_cfg.drop_fraction        = DROP_FRACTION_RST;
        focus_cfg.abort_position_limit = ABORT_LIMIT_RST;

        // reset defaults: idle score, climb, equal score, early stop, idle score
        add_row(move_row(ACT_SCORE, 0, 0, 32'd55, 0, 0, 0, 0, 0, 0));
        add_row(move_row(ACT_START, 0, 0, 0, 1, -15000, 0, 0, 0, 0));
        add_row(move_row(ACT_SCORE, 0, 0, 1000, 1, -14000, 0, 0, 1000, 1));
        add_row(move_row(ACT_SCORE, 0, 0, 1000, 1, -13000, 0, 0, 1000, 2));
        add_row(move_row(ACT_SCORE, 0, 0, 2000, 1, -12000, 0, 0, 2000, 3));
        add_row(move_row(ACT_SCORE, 0, 0, 1000, 1, -13000, 1, 1, 2000, 4));
        add_row(move_row(ACT_SCORE, 1, 0, 32'd7, 0, 0, 0, 0, 0, 0));
        // saturated sweep bounds, drop above the limit, restart mid search
        add_row(move_row(ACT_START, 1, 32'h7FFF_FFFF, 0, 1, 32'd2147478647,
                         0, 0, 0, 0));
        add_row(req_row(ACT_SCORE, 0, 0, 32'hFFFF_FFFF));
        add_row(req_row(ACT_SCORE, 0, 0, 0));
        add_row(move_row(ACT_START, 0, 32'h8000_0000, 0, 1, 32'h8000_0000,
                         0, 0, 0, 0));
        add_row(req_row(ACT_SCORE, 0, 0, 0));
        // zero span, zero step, span end
        add_row(cfg_row(REG_COARSE_SPAN, 0));
        add_row(cfg_row(REG_FINE_STEP, 0));
        add_row(cfg_row(REG_FINE_SPAN, 3));
        add_row(move_row(ACT_START, 0, 100, 0, 1, 100, 0, 0, 0, 0));
        add_row(move_row(ACT_SCORE, 0, 0, 9, 1, 100, 1, 0, 9, 1));
        add_row(move_row(ACT_START, 1, -5, 0, 1, -6, 0, 0, 0, 0));
        add_row(move_row(ACT_SCORE, 0, 0, 3, 1, -5, 0, 0, 3, 1));
        add_row(move_row(ACT_SCORE, 0, 0, 3, 1, -5, 1, 0, 3, 2));
        // drop just over the largest fraction
        add_row(cfg_row(REG_DROP_FRACTION, 32'hFFFF));
        add_row(cfg_row(REG_ABORT_LIMIT, 32'h7FFF_FFFF));
        add_row(move_row(ACT_START, 1, 0, 0, 1, -1, 0, 0, 0, 0));
        add_row(move_row(ACT_SCORE, 0, 0, 100, 1, 0, 0, 0, 100, 1));
        add_row(move_row(ACT_SCORE, 0, 0, 0, 1, -1, 1, 1, 100, 2));
        // lowest limit blocks the early stop
        add_row(cfg_row(REG_ABORT_LIMIT, 32'h8000_0000));
        add_row(req_row(ACT_START, 1, 0, 0));
        add_row(req_row(ACT_SCORE, 0, 0, 100));
        add_row(req_row(ACT_SCORE, 0, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_CFG)
                write_reg(plan[k].idx, plan[k].data);
            else
                send_request(plan[k].rq, plan[k].typed, plan[k].has_move, plan[k].move);
        end

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                1, 6:    apply_setup(SETUP_TOP);
                3:       apply_setup(SETUP_BOTTOM);
                4:       apply_setup(SETUP_TINY);
                default: apply_setup(SETUP_MODERATE);
            endcase
            if (p == 2 || p == 5)
                hold_requests++;
            phase_stop = n_items + PHASE_ITEMS;
            while (n_items < phase_stop)
                run_search();
        end

        in_valid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        $display("covered %0d searches: %0d early stops, %0d at span top, %0d idle scores",
                 n_searches, n_early, n_top, n_ignored);
        $display("%0d requests sent, %0d moves checked", n_items, n_checked);
        if (n_errors == 0 && pending_moves.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/afps_pkg.sv
rtl/afps_cfg_regs.sv
rtl/afps_search_core.sv
rtl/autofocus_peak_search_unit.sv
tb/sv/testbench.sv
